// ----- rtl/lru_kv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by the top level and its port checker.
`default_nettype none
package lru_kv_pkg;

  // Field widths fixed by the item format
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // Default slot count and capacity after reset
  localparam int DEFAULT_ENTRIES = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CAP_W-1:0] cap_t;

  // Operation codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Value returned on a miss and on every put
  localparam data_t NEG_ONE = '1;

endpackage
`default_nettype wire

// ----- rtl/lru_key_value_cache_top.sv -----
// An accepted item passes from the input register to the result register and
// waits in the input register while the result side stalls.
// Throughput: one item per cycle while results are taken; all slots compare
// keys and update their recency ranks in parallel between the two registers.
// Reset (synchronous, rst high) empties the cache, clears all ranks and sets
// the capacity to 16; no clearing pass is needed.
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lru_kv_pkg.
`default_nettype none
module lru_key_value_cache_top #(
  parameter int ENTRIES = lru_kv_pkg::DEFAULT_ENTRIES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire lru_kv_pkg::cap_t  cfg_wdata,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic              cmd,
  input  wire lru_kv_pkg::data_t lookup_key,
  input  wire lru_kv_pkg::data_t write_value,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output logic                   hit,
  output lru_kv_pkg::data_t      read_value
);
  import lru_kv_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Configuration
  cap_t capacity;

  // Input register
  logic  hold_valid;
  logic  hold_cmd;
  data_t hold_key;
  data_t hold_value;

  // Slot storage
  logic [ENTRIES-1:0]    slot_valid;
  data_t                 slot_key   [ENTRIES];
  data_t                 slot_value [ENTRIES];
  logic [RANK_W-1:0]     recency_rank [ENTRIES];
  logic [OCC_W-1:0]      occupancy;

  // Per-item decode
  logic                  advance;
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    free_vec;
  logic [ENTRIES-1:0]    lru_vec;
  logic [ENTRIES-1:0]    target_vec;
  logic                  match_any;
  logic                  free_any;
  logic                  free_seen;
  logic [RANK_W-1:0]     match_rank;
  data_t                 match_value;
  logic [CMP_W-1:0]      cap_eff;
  logic                  full;
  logic                  is_put;
  logic                  do_touch;
  logic                  do_insert;
  logic [OCC_W-1:0]      touch_rank;

  // Advance when the input register holds an item and the result slot frees up
  assign advance   = hold_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !hold_valid || advance;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold_cmd   <= cmd;
      hold_key   <= lookup_key;
      hold_value <= write_value;
    end
  end

  // Compare all slots, find the first free slot and the least recent one
  always_comb begin
    match_vec   = '0;
    free_vec    = '0;
    lru_vec     = '0;
    match_rank  = '0;
    match_value = '0;
    free_seen   = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = slot_valid[i] && (slot_key[i] == hold_key);
      lru_vec[i]   = slot_valid[i] && (OCC_W'(recency_rank[i]) == occupancy - OCC_W'(1));
      if (!slot_valid[i] && !free_seen) begin
        free_vec[i] = 1'b1;
        free_seen   = 1'b1;
      end
      match_rank  = match_rank  | (recency_rank[i] & {RANK_W{match_vec[i]}});
      match_value = match_value | (slot_value[i]   & {DATA_W{match_vec[i]}});
    end
  end

  assign match_any = |match_vec;
  assign free_any  = |free_vec;
  assign is_put    = (hold_cmd == CMD_PUT);

  // Clamp the capacity into one .. ENTRIES
  always_comb begin
    cap_eff = CMP_W'(capacity);
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end
    if (cap_eff > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  assign full = (CMP_W'(occupancy) >= cap_eff) || !free_any;

  // Pick the slot that becomes most recent and the rank threshold below it
  always_comb begin
    if (match_any) begin
      target_vec = match_vec;
      touch_rank = OCC_W'(match_rank);
    end else if (full) begin
      target_vec = lru_vec;
      touch_rank = occupancy - OCC_W'(1);
    end else begin
      target_vec = free_vec;
      touch_rank = occupancy;
    end
  end

  assign do_touch  = advance && (match_any || is_put);
  assign do_insert = advance && is_put && !match_any && !full;

  // Update valid bits, ranks and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      occupancy  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (do_insert) begin
        slot_valid <= slot_valid | target_vec;
        occupancy  <= occupancy + OCC_W'(1);
      end
      if (do_touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (target_vec[i]) begin
            recency_rank[i] <= '0;
          end else if (slot_valid[i] && (OCC_W'(recency_rank[i]) < touch_rank)) begin
            recency_rank[i] <= recency_rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  // Write the value into the chosen slot, and its key unless the key already matched
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (advance && is_put && target_vec[i]) begin
        slot_value[i] <= hold_value;
        if (!match_any) begin
          slot_key[i] <= hold_key;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit        <= match_any;
      read_value <= (!is_put && match_any) ? match_value : NEG_ONE;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lru_kv_checker.sv -----
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lru_kv_pkg.
`default_nettype none
module lru_kv_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic              hit,
  input wire lru_kv_pkg::data_t read_value
);
  import lru_kv_pkg::*;

  // Items accepted but not yet delivered
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'((req_valid && req_ready) ? 1 : 0)
                         - 3'((rsp_valid && rsp_ready) ? 1 : 0);
    end
  end

  // Reset drops any waiting result
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(read_value))
    else $error("stalled result changed");

  // A miss always reads back all ones
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hit |-> read_value == NEG_ONE)
    else $error("miss returned a value");

  // No result without an accepted item, and at most two in flight
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 3'd0)
    else $error("result without an accepted item");

  a_in_flight: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("too many items in flight");

endmodule

bind lru_key_value_cache_top lru_kv_checker u_lru_kv_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_ready  (req_ready),
  .rsp_valid  (rsp_valid),
  .rsp_ready  (rsp_ready),
  .hit        (hit),
  .read_value (read_value)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for lru_key_value_cache_top: random and directed get/put traffic
// checked item by item against an in-bench LRU cache predictor.
// Depends on lru_kv_pkg and the cache top level.
`timescale 1ns / 1ps
module tb_top;
  import lru_kv_pkg::*;

  localparam int SLOTS       = DEFAULT_ENTRIES;
  localparam int IDLE_PCT    = 26;
  localparam int HOLD_CYCLES = 120;
  localparam int POOL_SIZE   = 32;

  typedef struct {
    logic  op;
    data_t key;
    data_t val;
  } cache_req_t;

  typedef struct {
    logic  hit;
    data_t value;
  } cache_result_t;

  logic  clk         = 1'b0;
  logic  rst         = 1'b1;
  logic  cfg_we      = 1'b0;
  cap_t  cfg_wdata   = '0;
  logic  req_valid   = 1'b0;
  logic  req_ready;
  logic  cmd         = CMD_GET;
  data_t lookup_key  = '0;
  data_t write_value = '0;
  logic  rsp_valid;
  logic  rsp_ready   = 1'b0;
  logic  hit;
  data_t read_value;

  lru_key_value_cache_top #(.ENTRIES(SLOTS)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .cmd         (cmd),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .hit         (hit),
    .read_value  (read_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Items waiting to be offered and results the cache owes us
  cache_req_t    req_items_q[$];
  cache_result_t lookup_results_q[$];

  // Shadow copy of the cache contents and its capacity register
  logic  shadow_used [SLOTS];
  data_t shadow_key  [SLOTS];
  data_t shadow_val  [SLOTS];
  int    shadow_rank [SLOTS];
  int    shadow_fill;
  cap_t  shadow_capacity;

  // Traffic shaping controlled by the stimulus process
  logic calm        = 1'b0;
  int   hold_asked  = 0;
  int   hold_served = 0;
  int   hold_left   = 0;

  logic       req_taken = 1'b0;
  cache_req_t drv_item;

  int items_taken = 0;
  int results_ok  = 0;
  int hits_seen   = 0;
  int evictions   = 0;
  int cfg_writes  = 0;
  int errors      = 0;

  // Make a slot the most recent among the valid ones
  function automatic void promote_slot(int s);
    for (int i = 0; i < SLOTS; i++)
      if (shadow_used[i] && shadow_rank[i] < shadow_rank[s])
        shadow_rank[i]++;
    shadow_rank[s] = 0;
  endfunction

  // Apply one get or put to the shadow cache and return what the block must answer
  function automatic cache_result_t predict_cache_access(cache_req_t it);
    cache_result_t r;
    int found;
    int free_slot;
    int limit;
    int victim;
    int worst;
    r.hit     = 1'b0;
    r.value   = NEG_ONE;
    found     = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_used[i] && shadow_key[i] == it.key && found < 0) found = i;
      if (!shadow_used[i] && free_slot < 0) free_slot = i;
    end
    // Capacity zero acts as one, anything above the slot count as the slot count
    limit = (shadow_capacity == 0) ? 1 : int'(shadow_capacity);
    if (limit > SLOTS) limit = SLOTS;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (it.op == CMD_GET) r.value = shadow_val[found];
      else shadow_val[found] = it.val;
      promote_slot(found);
    end else if (it.op == CMD_PUT) begin
      if (shadow_fill >= limit || free_slot < 0) begin
        // Overwrite the least recent valid slot
        victim = 0;
        worst  = -1;
        for (int i = 0; i < SLOTS; i++)
          if (shadow_used[i] && shadow_rank[i] > worst) begin
            worst  = shadow_rank[i];
            victim = i;
          end
        shadow_key[victim] = it.key;
        shadow_val[victim] = it.val;
        promote_slot(victim);
        evictions++;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (shadow_used[i]) shadow_rank[i]++;
        shadow_used[free_slot] = 1'b1;
        shadow_key[free_slot]  = it.key;
        shadow_val[free_slot]  = it.val;
        shadow_rank[free_slot] = 0;
        shadow_fill++;
      end
    end
    return r;
  endfunction

  // Sample both handshakes, check results, predict accepted items
  always @(posedge clk) begin
    cache_result_t want;
    cache_result_t got;
    req_taken = req_valid && req_ready;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        shadow_used[i] = 1'b0;
        shadow_rank[i] = 0;
      end
      shadow_fill     = 0;
      shadow_capacity = CAP_RESET;
    end else begin
      if (rsp_valid && rsp_ready) begin
        got.hit   = hit;
        got.value = read_value;
        if (lookup_results_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0b read_value=%h", $time, hit, read_value);
          errors++;
        end else begin
          want = lookup_results_q.pop_front();
          if (got.hit !== want.hit || got.value !== want.value) begin
            $display("%0t: result mismatch: expected hit=%0b read_value=%h, actual hit=%0b read_value=%h",
                     $time, want.hit, want.value, got.hit, got.value);
            errors++;
          end else begin
            results_ok++;
            if (got.hit) hits_seen++;
          end
        end
      end
      if (cfg_we) shadow_capacity = cfg_wdata;
      if (req_taken) begin
        drv_item.op  = cmd;
        drv_item.key = lookup_key;
        drv_item.val = write_value;
        lookup_results_q.push_back(predict_cache_access(drv_item));
        items_taken++;
      end
    end
  end

  // Offer the next item once the current one is taken; idle at random
  always @(negedge clk) begin
    cache_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (req_items_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = req_items_q.pop_front();
        req_valid   <= 1'b1;
        cmd         <= nxt.op;
        lookup_key  <= nxt.key;
        write_value <= nxt.val;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Accept results; stall at random or for a long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      rsp_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic queue_item(logic op, data_t key, data_t val);
    cache_req_t it;
    it.op  = op;
    it.key = key;
    it.val = val;
    req_items_q.push_back(it);
  endtask

  // Wait until every item is sent and every result has come back
  task automatic drain_traffic();
    while (req_items_q.size() != 0 || req_valid || lookup_results_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(cap_t c);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    data_t key_pool[POOL_SIZE];
    cap_t  phase_cap[10];
    int    pool_n;
    data_t k;
    data_t v;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    phase_cap = '{5'd31, 5'd16, 5'd4, 5'd1, 5'd17, 5'd0, 5'd2, 5'd8, 5'd12, 5'd3};
    phase_cap[8] = cap_t'($urandom_range(31));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extreme keys and values, hits, a miss, an update
    queue_item(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_item(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(CMD_PUT, '0, '0);
    queue_item(CMD_PUT, '1, '1);
    queue_item(CMD_GET, 32'h8000_0000, '0);
    queue_item(CMD_GET, 32'h7FFF_FFFF, '1);
    queue_item(CMD_GET, '0, 32'h1234_5678);
    queue_item(CMD_GET, '1, '0);
    queue_item(CMD_GET, 32'd1, '0);
    queue_item(CMD_PUT, '0, 32'h5A5A_5A5A);
    queue_item(CMD_GET, '0, '0);
    queue_item(CMD_GET, 32'h8000_0000, '0);
    drain_traffic();

    // Lower the capacity below occupancy: new keys replace the least recent
    write_capacity(5'd2);
    queue_item(CMD_PUT, 32'd7, 32'd70);
    queue_item(CMD_GET, 32'h7FFF_FFFF, '0);
    queue_item(CMD_PUT, 32'd8, 32'd80);
    queue_item(CMD_GET, '1, '0);
    drain_traffic();

    // Capacity zero behaves as one
    write_capacity(5'd0);
    queue_item(CMD_PUT, 32'd9, 32'hA5A5_A5A5);
    queue_item(CMD_GET, 32'd9, '0);
    queue_item(CMD_PUT, 32'd9, 32'hFFFF_0000);
    drain_traffic();

    // Random phases, one capacity setting each
    for (int ph = 0; ph < 10; ph++) begin
      write_capacity(phase_cap[ph]);
      for (int i = 4; i < POOL_SIZE; i++)
        if ($urandom_range(99) < 30) key_pool[i] = $urandom;
      pool_n = $urandom_range(2, POOL_SIZE);
      // Run one phase without any idling, and one under a long result stall
      calm = (ph == 1);
      if (ph == 2) hold_asked++;
      for (int n = 0; n < 63; n++) begin
        k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)] : data_t'($urandom);
        case ($urandom_range(9))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '1;
          default: v = $urandom;
        endcase
        queue_item(logic'($urandom_range(1)), k, v);
      end
      drain_traffic();
      calm = 1'b0;
    end

    repeat (8) @(posedge clk);
    if (lookup_results_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, lookup_results_q.size());
      errors++;
    end
    $display("Ran %0d items over %0d capacity settings: %0d results matched, %0d hits, %0d evictions.",
             items_taken, cfg_writes, results_ok, hits_seen, evictions);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a run that hangs
  initial begin
    #8_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, lookup_results_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
